// ----- rtl/program_pid_association_table_assert.svh -----
// assertion macros for the program/pid association table
// used by the top level; needs a clock named clock and a reset named reset
`ifndef PROGRAM_PID_ASSOCIATION_TABLE_ASSERT_SVH
`define PROGRAM_PID_ASSOCIATION_TABLE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PAT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pat assertion failed");

// antecedent implies consequent in the next cycle
`define PAT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pat assertion failed");

`endif

// ----- rtl/pat_pkg.sv -----
// shared types and constants for the program/pid association table
// no dependencies
package pat_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int PROG_W      = 16;
   localparam int PID_W       = 13;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_FULL     = 3'd2,
      ST_FOUND    = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_REMOVED  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic [PROG_W-1:0] prog_num;
      logic [PID_W-1:0]  pid;
   } entry_type;

   // write side of the entry memory
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } wr_port_type;

endpackage

// ----- rtl/pat_ram.sv -----
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module pat_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/program_pid_association_table.sv -----
// top level of the program/pid association table: sequencer around one entry memory
// depends on pat_pkg, pat_ram and program_pid_association_table_assert.svh
//
// usage
//   a request (req_operation, req_prog_num, req_pid) is taken on a clock edge
//   with start high and busy low; busy stays high until it is finished. each
//   request gives one response on rsp_status and rsp_found_pid, shown for one
//   cycle with rsp_strobe high; the receiver cannot stall it.
// timing
//   the held entries are read one a cycle through the memory read port. the
//   scan runs over every held entry, then a done state registers the
//   response; the strobe rises and busy falls with it, so the next request
//   is taken only after the last is answered. a full table holds 32 entries.
//   the unused operation code (3) skips the scan. remove compacts the table
//   in the same pass, writing survivors back behind the read pointer.
// reset
//   synchronous reset empties the table (entry count to zero) and drops busy
//   and the strobe; memory contents are kept and never read past the count.
module program_pid_association_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_operation,
   input  logic [pat_pkg::PROG_W-1:0] req_prog_num,
   input  logic [pat_pkg::PID_W-1:0]  req_pid,
   output logic                       rsp_strobe,
   output logic [2:0]                 rsp_status,
   output logic [pat_pkg::PID_W-1:0]  rsp_found_pid
);

   import pat_pkg::*;

   `include "program_pid_association_table_assert.svh"

   fsm_type           state_ff, state_in;
   op_type            op_ff, op_in;
   logic [PROG_W-1:0] prog_ff, prog_in;
   logic [PID_W-1:0]  pid_ff, pid_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  wr_ff, wr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              dvld_ff, dvld_in;
   logic              hit_ff, hit_in;
   logic [PID_W-1:0]  hitpid_ff, hitpid_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [PID_W-1:0]  rsp_pid_ff, rsp_pid_in;

   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [$bits(entry_type)-1:0] rd_raw;
   entry_type         rd_entry;
   wr_port_type       wr_port;
   logic              issue;

   // entry memory
   pat_ram #(
      .DATA_W ($bits(entry_type)),
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_port.en),
      .wr_addr (wr_port.addr),
      .wr_data (wr_port.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = entry_type'(rd_raw);
   assign rd_addr  = idx_ff[ADDR_W-1:0];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         count_ff      <= '0;
         dvld_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dvld_ff       <= dvld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // request and scan payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      prog_ff       <= prog_in;
      pid_ff        <= pid_in;
      idx_ff        <= idx_in;
      wr_ff         <= wr_in;
      hit_ff        <= hit_in;
      hitpid_ff     <= hitpid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pid_ff    <= rsp_pid_in;
   end

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      prog_in       = prog_ff;
      pid_in        = pid_ff;
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      count_in      = count_ff;
      dvld_in       = 1'b0;
      hit_in        = hit_ff;
      hitpid_in     = hitpid_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pid_in    = rsp_pid_ff;
      rd_en         = 1'b0;
      issue         = 1'b0;
      wr_port.en    = 1'b0;
      wr_port.addr  = wr_ff[ADDR_W-1:0];
      wr_port.data  = rd_entry;

      unique case (state_ff)
         FSM_IDLE: begin
            // take a new request
            if (start) begin
               op_in     = op_type'(req_operation);
               prog_in   = req_prog_num;
               pid_in    = req_pid;
               idx_in    = '0;
               wr_in     = '0;
               hit_in    = 1'b0;
               hitpid_in = '0;
               state_in  = (op_type'(req_operation) == OP_NONE) ? FSM_DONE : FSM_SCAN;
            end
         end

         FSM_SCAN: begin
            // issue one read per cycle over the held entries
            issue   = (idx_ff < count_ff);
            rd_en   = issue;
            dvld_in = issue;
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            // compare the entry that came back from the memory
            if (dvld_ff) begin
               unique case (op_ff)
                  OP_ADD: begin
                     if (rd_entry.prog_num == prog_ff && rd_entry.pid == pid_ff) begin
                        hit_in = 1'b1;
                     end
                  end
                  OP_LOOKUP: begin
                     // later entries are newer, so the last match wins
                     if (rd_entry.prog_num == prog_ff) begin
                        hit_in    = 1'b1;
                        hitpid_in = rd_entry.pid;
                     end
                  end
                  OP_REMOVE: begin
                     // survivors are written back behind the read pointer
                     if (rd_entry.prog_num != prog_ff) begin
                        wr_port.en = 1'b1;
                        wr_in      = wr_ff + CNT_W'(1);
                     end
                  end
                  OP_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
            if (!issue && !dvld_ff) begin
               state_in = FSM_DONE;
            end
         end

         FSM_DONE: begin
            // settle the response and any table update
            rsp_strobe_in = 1'b1;
            rsp_pid_in    = '0;
            state_in      = FSM_IDLE;
            unique case (op_ff)
               OP_ADD: begin
                  if (hit_ff) begin
                     rsp_status_in = ST_PRESENT;
                  end else if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     rsp_status_in         = ST_ADDED;
                     wr_port.en            = 1'b1;
                     wr_port.addr          = count_ff[ADDR_W-1:0];
                     wr_port.data.prog_num = prog_ff;
                     wr_port.data.pid      = pid_ff;
                     count_in              = count_ff + CNT_W'(1);
                  end
               end
               OP_REMOVE: begin
                  rsp_status_in = ST_REMOVED;
                  count_in      = wr_ff;
               end
               OP_LOOKUP: begin
                  if (hit_ff) begin
                     rsp_status_in = ST_FOUND;
                     rsp_pid_in    = hitpid_ff;
                  end else begin
                     rsp_status_in = ST_NOTFOUND;
                  end
               end
               OP_NONE: begin
                  rsp_status_in = ST_NOTFOUND;
               end
               default: begin
                  rsp_status_in = ST_NOTFOUND;
               end
            endcase
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff != FSM_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found_pid = rsp_pid_ff;

   // checks
   `PAT_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `PAT_ASSERT_NEXT(a_start_busy, start && !busy, busy)
   `PAT_ASSERT_NEXT(a_done_strobe, state_ff == FSM_DONE, rsp_strobe && !busy)
   `PAT_ASSERT_SAME(a_compact_behind, state_ff == FSM_SCAN && wr_port.en, wr_ff < idx_ff)

endmodule
